// File: sv/sdlt_pkg.sv
// ----------------------------------------------------------------------------
// Sorted descending list table package
// Request and status codes, cell commands and cell flag types shared by the
// table core and its storage cells.
// ----------------------------------------------------------------------------
package sdlt_pkg;

  // Port field widths.
  localparam int REQ_W        = 3;
  localparam int KEY_PORT_W   = 32;
  localparam int STATUS_W     = 2;
  localparam int COUNT_PORT_W = 7;
  // Widest key the table supports; used to extend and cut key values.
  localparam int MAX_KEY_W    = 64;

  // Request codes.
  localparam logic [REQ_W-1:0] REQ_INSERT = 3'd0;
  localparam logic [REQ_W-1:0] REQ_DELETE = 3'd1;
  localparam logic [REQ_W-1:0] REQ_FIND   = 3'd2;
  localparam logic [REQ_W-1:0] REQ_REWIND = 3'd3;
  localparam logic [REQ_W-1:0] REQ_READ   = 3'd4;
  localparam logic [REQ_W-1:0] REQ_CLEAR  = 3'd5;

  // Status codes.
  localparam logic [STATUS_W-1:0] STAT_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_FULL      = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_NOT_FOUND = 2'd2;
  localparam logic [STATUS_W-1:0] STAT_END       = 2'd3;

  // Command broadcast to every cell of the chain.
  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_EVAL,
    CELL_INSERT,
    CELL_DELETE
  } cell_cmd_t;

  // Per-cell compare results, captured during evaluation.
  typedef struct packed {
    logic gt;       // cell holds a valid key greater than the request key
    logic eq;       // cell holds a valid key equal to the request key
    logic at_cur;   // cell index equals the read cursor
    logic at_prev;  // cell index is one below the read cursor
  } cell_flags_t;

endpackage

// File: sv/sdlt_cell.sv
// ----------------------------------------------------------------------------
// Sorted descending list table cell
// Holds one key, compares it against the broadcast key and shifts toward
// either neighbor on insert or delete.
// ----------------------------------------------------------------------------
module sdlt_cell #(
  parameter int IDX       = 0,
  parameter int KEY_WIDTH = 32,
  parameter int CNT_W     = 7
) (
  input  logic                  clk,
  input  sdlt_pkg::cell_cmd_t   cmd,
  input  logic [KEY_WIDTH-1:0]  key_in,
  input  logic [CNT_W-1:0]      count,
  input  logic [CNT_W-1:0]      cursor,
  input  logic [KEY_WIDTH-1:0]  left_key,
  input  logic                  left_gt,
  input  logic [KEY_WIDTH-1:0]  right_key,
  output logic [KEY_WIDTH-1:0]  cell_key,
  output sdlt_pkg::cell_flags_t cell_flags
);
  import sdlt_pkg::*;

  logic [KEY_WIDTH-1:0] key_r;
  logic [KEY_WIDTH-1:0] key_nxt;
  cell_flags_t          flags_r;
  cell_flags_t          flags_nxt;
  logic                 valid;

  assign valid = CNT_W'(IDX) < count;

  always_comb begin
    flags_nxt.gt      = valid && (key_r > key_in);
    flags_nxt.eq      = valid && (key_r == key_in);
    flags_nxt.at_cur  = CNT_W'(IDX) == cursor;
    flags_nxt.at_prev = CNT_W'(IDX + 1) == cursor;
  end

  // Keys ahead of the insert or delete point keep their place; the rest
  // move one step right (insert) or left (delete).
  always_comb begin
    key_nxt = key_r;
    unique case (cmd)
      CELL_INSERT: begin
        if (!flags_r.gt) begin
          key_nxt = left_gt ? key_in : left_key;
        end
      end
      CELL_DELETE: begin
        if (!flags_r.gt) begin
          key_nxt = right_key;
        end
      end
      default: key_nxt = key_r;
    endcase
  end

  always_ff @(posedge clk) begin
    key_r <= key_nxt;
    if (cmd == CELL_EVAL) begin
      flags_r <= flags_nxt;
    end
  end

  assign cell_key   = key_r;
  assign cell_flags = flags_r;

endmodule

// File: sv/sorted_descending_list_table_core.sv
// ----------------------------------------------------------------------------
// Sorted descending list table core
// Keeps up to CAPACITY keys in descending order in a chain of cells and
// serves insert, delete, find, rewind, read next and clear requests.
// ----------------------------------------------------------------------------
//
//  Channel  | Ports                                  | Direction
//  ---------+----------------------------------------+--------------------
//  request  | in_valid, in_stall, in_req_type,       | into the core
//           | in_key_value                           |
//  result   | out_valid, out_stall, out_status,      | out of the core
//           | out_item_value, out_entry_count,       |
//           | out_at_end                             |
//
// Every request is handled in steps: the request is captured, every cell
// compares its key against the request key and registers its flags, and then
// the flags are merged, the chain shifts and the result register is loaded.
// A new request is accepted in the cycle the result register is emptied, and
// never before the previous request has loaded its result.
// Reset (rst_n low, synchronous) empties the table and rewinds the cursor;
// stored keys are not cleared and are only read below the entry count.
// A stalled result holds its register and blocks the next request.
//
module sorted_descending_list_table_core #(
  parameter int CAPACITY  = 64,
  parameter int KEY_WIDTH = 32
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [sdlt_pkg::REQ_W-1:0]           in_req_type,
  input  logic [sdlt_pkg::KEY_PORT_W-1:0]      in_key_value,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [sdlt_pkg::STATUS_W-1:0]        out_status,
  output logic [sdlt_pkg::KEY_PORT_W-1:0]      out_item_value,
  output logic [sdlt_pkg::COUNT_PORT_W-1:0]    out_entry_count,
  output logic                                 out_at_end
);
  import sdlt_pkg::*;

  localparam int CNT_W = $clog2(CAPACITY + 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EVAL,
    ST_APPLY
  } state_t;

  state_t                state_r;
  logic [REQ_W-1:0]      op_r;
  logic [KEY_WIDTH-1:0]  key_r;
  logic [CNT_W-1:0]      count_r;
  logic [CNT_W-1:0]      cursor_r;
  logic                  out_valid_r;
  logic [STATUS_W-1:0]   out_status_r;
  logic [KEY_PORT_W-1:0] out_item_r;
  logic [COUNT_PORT_W-1:0] out_count_r;
  logic                  out_at_end_r;

  logic [CNT_W-1:0]      count_nxt;
  logic [CNT_W-1:0]      cursor_nxt;
  logic [STATUS_W-1:0]   status_nxt;
  logic [KEY_WIDTH-1:0]  item_nxt;
  logic [MAX_KEY_W-1:0]  key_ext;
  logic [MAX_KEY_W-1:0]  item_ext;
  logic [MAX_KEY_W-1:0]  count_ext;

  cell_cmd_t             cell_cmd;
  logic [KEY_WIDTH-1:0]  cell_key   [CAPACITY];
  cell_flags_t           cell_flags [CAPACITY];

  logic                  any_eq;
  logic                  gt_cur;
  logic                  gt_prev;
  logic [KEY_WIDTH-1:0]  rd_key;
  logic                  full;
  logic                  cur_end;
  logic                  in_accept;
  logic                  out_take;

  assign out_take  = out_valid_r && !out_stall;
  assign in_stall  = (state_r != ST_IDLE) || (out_valid_r && out_stall);
  assign in_accept = in_valid && !in_stall;

  // The request key is masked to KEY_WIDTH bits (zero extended when wider).
  assign key_ext = MAX_KEY_W'(in_key_value);

  // The chain of cells. Cell zero sees a greater-than neighbor on its left,
  // so an insert at the head lands in it; the last cell refills from itself.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    sdlt_cell #(
      .IDX       (i),
      .KEY_WIDTH (KEY_WIDTH),
      .CNT_W     (CNT_W)
    ) u_cell (
      .clk        (clk),
      .cmd        (cell_cmd),
      .key_in     (key_r),
      .count      (count_r),
      .cursor     (cursor_r),
      .left_key   ((i == 0) ? key_r : cell_key[(i == 0) ? 0 : i - 1]),
      .left_gt    ((i == 0) ? 1'b1 : cell_flags[(i == 0) ? 0 : i - 1].gt),
      .right_key  (cell_key[(i == CAPACITY - 1) ? i : i + 1]),
      .cell_key   (cell_key[i]),
      .cell_flags (cell_flags[i])
    );
  end

  // Merge of the registered cell flags. Keys greater than the request key
  // form a prefix of the table, so the insert point and the first equal key
  // both sit right after the last cell with its greater flag set.
  always_comb begin
    any_eq  = 1'b0;
    gt_cur  = 1'b0;
    gt_prev = 1'b0;
    rd_key  = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      any_eq  = any_eq  | cell_flags[i].eq;
      gt_cur  = gt_cur  | (cell_flags[i].gt & cell_flags[i].at_cur);
      gt_prev = gt_prev | (cell_flags[i].gt & cell_flags[i].at_prev);
      rd_key  = rd_key  | (cell_key[i] & {KEY_WIDTH{cell_flags[i].at_cur}});
    end
  end

  assign full    = count_r == CNT_W'(CAPACITY);
  assign cur_end = cursor_r >= count_r;

  // Result and state update, evaluated in the apply cycle.
  always_comb begin
    count_nxt  = count_r;
    cursor_nxt = cursor_r;
    status_nxt = STAT_OK;
    item_nxt   = '0;
    unique case (op_r)
      REQ_INSERT: begin
        item_nxt = key_r;
        if (full) begin
          status_nxt = STAT_FULL;
        end else begin
          count_nxt = count_r + 1'b1;
          // The new key lands at or before the cursor: keep the cursor on
          // its entry (or at the end).
          if (cur_end || !gt_cur) begin
            cursor_nxt = cursor_r + 1'b1;
          end
        end
      end
      REQ_DELETE: begin
        item_nxt = key_r;
        if (!any_eq) begin
          status_nxt = STAT_NOT_FOUND;
        end else begin
          count_nxt = count_r - 1'b1;
          // The cursor is past the removed entry when the entry just below
          // it is not greater than the key.
          if ((cursor_r != '0) && !gt_prev) begin
            cursor_nxt = cursor_r - 1'b1;
          end
        end
      end
      REQ_FIND: begin
        item_nxt = key_r;
        if (!any_eq) begin
          status_nxt = STAT_NOT_FOUND;
        end
      end
      REQ_REWIND: begin
        cursor_nxt = '0;
      end
      REQ_READ: begin
        if (cur_end) begin
          status_nxt = STAT_END;
        end else begin
          item_nxt   = rd_key;
          cursor_nxt = cursor_r + 1'b1;
        end
      end
      REQ_CLEAR: begin
        count_nxt  = '0;
        cursor_nxt = '0;
      end
      default: begin
        status_nxt = STAT_OK;
      end
    endcase
  end

  assign item_ext  = MAX_KEY_W'(item_nxt);
  assign count_ext = MAX_KEY_W'(count_nxt);

  // The chain only shifts when the request really changes the table.
  always_comb begin
    cell_cmd = CELL_HOLD;
    unique case (state_r)
      ST_EVAL: cell_cmd = CELL_EVAL;
      ST_APPLY: begin
        if ((op_r == REQ_INSERT) && !full) begin
          cell_cmd = CELL_INSERT;
        end else if ((op_r == REQ_DELETE) && any_eq) begin
          cell_cmd = CELL_DELETE;
        end
      end
      default: cell_cmd = CELL_HOLD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      count_r     <= '0;
      cursor_r    <= '0;
    end else begin
      if (out_take) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (in_accept) begin
            op_r    <= in_req_type;
            key_r   <= key_ext[KEY_WIDTH-1:0];
            state_r <= ST_EVAL;
          end
        end
        ST_EVAL: begin
          state_r <= ST_APPLY;
        end
        ST_APPLY: begin
          count_r      <= count_nxt;
          cursor_r     <= cursor_nxt;
          out_valid_r  <= 1'b1;
          out_status_r <= status_nxt;
          out_item_r   <= item_ext[KEY_PORT_W-1:0];
          out_count_r  <= count_ext[COUNT_PORT_W-1:0];
          out_at_end_r <= cursor_nxt >= count_nxt;
          state_r      <= ST_IDLE;
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_item_value  = out_item_r;
  assign out_entry_count = out_count_r;
  assign out_at_end      = out_at_end_r;

`ifndef SYNTH
  // The cursor never runs past the last stored key.
  a_cursor_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    cursor_r <= count_r)
    else $error("read cursor beyond entry count");

  // The entry count never exceeds the capacity.
  a_count_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(CAPACITY))
    else $error("entry count beyond capacity");

  // A request is only taken when the result register is free by evaluation.
  a_out_free_in_eval: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EVAL) |-> !out_valid_r)
    else $error("result register busy while a request is evaluated");

  // An insert into a full table leaves the count unchanged.
  a_full_insert_drops: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_APPLY) && (op_r == REQ_INSERT) && full)
    |=> (count_r == CNT_W'(CAPACITY)))
    else $error("insert into full table changed the count");
`endif

endmodule

// File: verif/tb_sorted_descending_list_table_core.sv
// ----------------------------------------------------------------------------
// Sorted descending list table core testbench
// Runs a short table of directed requests and then long random phases that
// fill, drain, walk and clear the table. A shadow copy of the table in the
// testbench predicts each result, and every result is checked field by field.
// ----------------------------------------------------------------------------
module tb_sorted_descending_list_table_core;
  import sdlt_pkg::*;

  localparam int CAPACITY  = 64;
  localparam int KEY_WIDTH = 32;

  // Request codes six and seven have no function; the core must ignore them.
  localparam logic [REQ_W-1:0] REQ_SPARE_LO = 3'd6;
  localparam logic [REQ_W-1:0] REQ_SPARE_HI = 3'd7;

  localparam int RANDOM_REQUESTS = 1850;
  localparam int MAX_REPORTS     = 10;

  typedef struct packed {
    logic [STATUS_W-1:0]     status;
    logic [KEY_PORT_W-1:0]   item;
    logic [COUNT_PORT_W-1:0] count;
    logic                    at_end;
  } table_result_t;

  // One row of the directed table. When fixed_result is set, the result is
  // typed in the row; otherwise the shadow table supplies it.
  typedef struct packed {
    logic [REQ_W-1:0]      req;
    logic [KEY_PORT_W-1:0] key;
    logic                  fixed_result;
    table_result_t         result;
  } directed_row_t;

  typedef enum int {PH_FILL, PH_DRAIN, PH_WALK, PH_MIXED, PH_NOISE} phase_t;

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    in_valid = 1'b0;
  logic                    in_stall;
  logic [REQ_W-1:0]        in_req_type = REQ_INSERT;
  logic [KEY_PORT_W-1:0]   in_key_value = '0;
  logic                    out_valid;
  logic                    out_stall = 1'b0;
  logic [STATUS_W-1:0]     out_status;
  logic [KEY_PORT_W-1:0]   out_item_value;
  logic [COUNT_PORT_W-1:0] out_entry_count;
  logic                    out_at_end;

  sorted_descending_list_table_core #(
    .CAPACITY (CAPACITY),
    .KEY_WIDTH(KEY_WIDTH)
  ) uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_req_type    (in_req_type),
    .in_key_value   (in_key_value),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_status     (out_status),
    .out_item_value (out_item_value),
    .out_entry_count(out_entry_count),
    .out_at_end     (out_at_end)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow copy of the table: keys in descending order, entry count and the
  // read cursor, updated once per accepted request.
  logic [KEY_PORT_W-1:0] shadow_keys [CAPACITY];
  int                    shadow_count  = 0;
  int                    shadow_cursor = 0;

  // Results the core still owes, oldest first.
  table_result_t results_due [$];

  int failures    = 0;
  int tx_max_gap  = 5;
  int rx_max_gap  = 5;
  int rx_wait     = 0;

  // Index of the first stored key equal to the given key, or the entry count
  // when the key is absent.
  function automatic int shadow_first_equal(logic [KEY_PORT_W-1:0] key);
    for (int i = 0; i < shadow_count; i++)
      if (shadow_keys[i] == key) return i;
    return shadow_count;
  endfunction

  // Applies one request to the shadow table and returns the result it yields.
  function automatic table_result_t apply_to_shadow_table(logic [REQ_W-1:0] req,
                                                          logic [KEY_PORT_W-1:0] key);
    table_result_t r;
    int            pos;
    r = '0;
    r.status = STAT_OK;
    case (req)
      REQ_INSERT: begin
        r.item = key;
        if (shadow_count >= CAPACITY) begin
          r.status = STAT_FULL;
        end else begin
          // The new key goes ahead of the first key that is not greater.
          pos = 0;
          while (pos < shadow_count && shadow_keys[pos] > key) pos++;
          for (int i = shadow_count; i > pos; i--) shadow_keys[i] = shadow_keys[i-1];
          shadow_keys[pos] = key;
          shadow_count++;
          // The cursor follows its entry when the new key lands at or ahead of it.
          if (pos <= shadow_cursor) shadow_cursor++;
        end
      end
      REQ_DELETE: begin
        r.item = key;
        pos = shadow_first_equal(key);
        if (pos >= shadow_count) begin
          r.status = STAT_NOT_FOUND;
        end else begin
          for (int i = pos; i + 1 < shadow_count; i++) shadow_keys[i] = shadow_keys[i+1];
          shadow_count--;
          if (shadow_cursor > pos) shadow_cursor--;
        end
      end
      REQ_FIND: begin
        r.item = key;
        if (shadow_first_equal(key) >= shadow_count) r.status = STAT_NOT_FOUND;
      end
      REQ_REWIND: begin
        shadow_cursor = 0;
      end
      REQ_READ: begin
        if (shadow_cursor >= shadow_count) begin
          r.status = STAT_END;
        end else begin
          r.item = shadow_keys[shadow_cursor];
          shadow_cursor++;
        end
      end
      REQ_CLEAR: begin
        shadow_count  = 0;
        shadow_cursor = 0;
      end
      default: ;
    endcase
    r.count  = shadow_count[COUNT_PORT_W-1:0];
    r.at_end = (shadow_cursor >= shadow_count);
    return r;
  endfunction

  // Offers one request after a random idle gap and holds it until the core
  // takes it. The expected result is queued at the edge of acceptance.
  task automatic send_request(input logic [REQ_W-1:0] req, input logic [KEY_PORT_W-1:0] key,
                              input logic fixed_result, input table_result_t fixed);
    int            gap;
    table_result_t predicted;
    gap = $urandom_range(0, tx_max_gap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_req_type  <= req;
    in_key_value <= key;
    do @(posedge clk); while (in_stall !== 1'b0);
    predicted = apply_to_shadow_table(req, key);
    results_due.push_back(fixed_result ? fixed : predicted);
  endtask

  // Holds off new requests until the core has returned every result.
  task automatic wait_until_drained();
    in_valid <= 1'b0;
    while (results_due.size() != 0) @(posedge clk);
  endtask

  // Keys lean on a few small values and the extremes so that duplicates,
  // hits on find and delete, and ties at both ends of the range are common.
  function automatic logic [KEY_PORT_W-1:0] pick_key(bit prefer_stored);
    int r;
    r = $urandom_range(0, 99);
    if (prefer_stored && shadow_count > 0 && r < 60)
      return shadow_keys[$urandom_range(0, shadow_count - 1)];
    r = $urandom_range(0, 99);
    if (r < 40) return KEY_PORT_W'($urandom_range(0, 15));
    if (r < 55) begin
      case ($urandom_range(0, 3))
        0:       return '0;
        1:       return '1;
        2:       return 32'h7FFF_FFFF;
        default: return 32'h8000_0000;
      endcase
    end
    return $urandom;
  endfunction

  function automatic logic [REQ_W-1:0] pick_request(phase_t phase);
    int r;
    r = $urandom_range(0, 99);
    case (phase)
      PH_FILL: begin
        if (r < 85) return REQ_INSERT;
        if (r < 90) return REQ_FIND;
        if (r < 95) return REQ_READ;
        return REQ_DELETE;
      end
      PH_DRAIN: begin
        if (r < 70) return REQ_DELETE;
        if (r < 80) return REQ_FIND;
        if (r < 90) return REQ_READ;
        return REQ_INSERT;
      end
      PH_WALK: begin
        if (r < 10) return REQ_REWIND;
        if (r < 65) return REQ_READ;
        if (r < 80) return REQ_INSERT;
        if (r < 95) return REQ_DELETE;
        return REQ_FIND;
      end
      PH_MIXED: begin
        if (r < 25) return REQ_INSERT;
        if (r < 45) return REQ_DELETE;
        if (r < 60) return REQ_FIND;
        if (r < 68) return REQ_REWIND;
        if (r < 90) return REQ_READ;
        if (r < 93) return REQ_CLEAR;
        return ($urandom_range(0, 1) != 0) ? REQ_SPARE_HI : REQ_SPARE_LO;
      end
      default: begin
        if (r < 30) return ($urandom_range(0, 1) != 0) ? REQ_SPARE_HI : REQ_SPARE_LO;
        if (r < 40) return REQ_CLEAR;
        return REQ_REWIND - REQ_REWIND + REQ_W'($urandom_range(0, 4));
      end
    endcase
  endfunction

  // Result side: each accepted result is compared with the oldest one due.
  // After every result the receiver draws how many cycles it stalls.
  always @(posedge clk) begin
    table_result_t got;
    table_result_t want;
    got = '{out_status, out_item_value, out_entry_count, out_at_end};
    if (rst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (results_due.size() == 0) begin
        failures++;
        if (failures <= MAX_REPORTS)
          $display("unexpected result: status %0d item %h count %0d at_end %0b",
                   got.status, got.item, got.count, got.at_end);
      end else begin
        want = results_due.pop_front();
        if (got.status !== want.status || got.item !== want.item ||
            got.count !== want.count || got.at_end !== want.at_end) begin
          failures++;
          if (failures <= MAX_REPORTS)
            $display({"result mismatch: expected status %0d item %h count %0d ",
                      "at_end %0b, got status %0d item %h count %0d at_end %0b"},
                     want.status, want.item, want.count, want.at_end,
                     got.status, got.item, got.count, got.at_end);
        end
      end
      rx_wait = $urandom_range(0, rx_max_gap);
    end
    if (rx_wait > 0) begin
      out_stall <= 1'b1;
      rx_wait--;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Directed requests. Rows with a typed result cover the empty table, the
  // extreme keys and the clear; the rest rely on the shadow table.
  directed_row_t directed_rows [25] = '{
    // Read, find and delete on an empty table.
    '{REQ_READ,     32'h0000_0000, 1'b1, '{STAT_END,       32'h0000_0000, 7'd0, 1'b1}},
    '{REQ_FIND,     32'h0000_0000, 1'b1, '{STAT_NOT_FOUND, 32'h0000_0000, 7'd0, 1'b1}},
    '{REQ_DELETE,   32'hFFFF_FFFF, 1'b1, '{STAT_NOT_FOUND, 32'hFFFF_FFFF, 7'd0, 1'b1}},
    // The first insert lands on the cursor, which moves past it to the end.
    '{REQ_INSERT,   32'hFFFF_FFFF, 1'b1, '{STAT_OK,        32'hFFFF_FFFF, 7'd1, 1'b1}},
    '{REQ_INSERT,   32'h0000_0000, 1'b0, '0},
    '{REQ_INSERT,   32'h8000_0000, 1'b0, '0},
    // Duplicate key.
    '{REQ_INSERT,   32'h8000_0000, 1'b0, '0},
    '{REQ_REWIND,   32'h0000_0000, 1'b0, '0},
    '{REQ_READ,     32'h0000_0000, 1'b0, '0},
    '{REQ_READ,     32'h0000_0000, 1'b0, '0},
    // Insert ahead of the cursor, then delete a key equal to the entry under the cursor.
    '{REQ_INSERT,   32'h9000_0000, 1'b0, '0},
    '{REQ_DELETE,   32'h8000_0000, 1'b0, '0},
    '{REQ_FIND,     32'h0000_0000, 1'b0, '0},
    '{REQ_FIND,     32'h1234_5678, 1'b0, '0},
    '{REQ_DELETE,   32'h1234_5678, 1'b0, '0},
    // Unused codes with alternating key bits.
    '{REQ_SPARE_LO, 32'hAAAA_AAAA, 1'b0, '0},
    '{REQ_SPARE_HI, 32'h5555_5555, 1'b0, '0},
    // Read to the end and twice past it.
    '{REQ_READ,     32'h0000_0000, 1'b0, '0},
    '{REQ_READ,     32'h0000_0000, 1'b0, '0},
    '{REQ_READ,     32'h0000_0000, 1'b0, '0},
    '{REQ_READ,     32'h0000_0000, 1'b0, '0},
    '{REQ_DELETE,   32'hFFFF_FFFF, 1'b0, '0},
    // Clear empties the table and rewinds the cursor.
    '{REQ_CLEAR,    32'h0000_0000, 1'b1, '{STAT_OK,        32'h0000_0000, 7'd0, 1'b1}},
    '{REQ_READ,     32'h0000_0000, 1'b1, '{STAT_END,       32'h0000_0000, 7'd0, 1'b1}},
    '{REQ_INSERT,   32'h7FFF_FFFF, 1'b0, '0}
  };

  initial begin
    int               counted;
    int               len;
    phase_t           phase;
    logic [REQ_W-1:0] req;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i])
      send_request(directed_rows[i].req, directed_rows[i].key,
                   directed_rows[i].fixed_result, directed_rows[i].result);

    // Let the core go fully idle once before the random phases begin.
    wait_until_drained();

    counted = 0;
    while (counted < RANDOM_REQUESTS) begin
      case ($urandom_range(0, 9))
        0, 1, 2: phase = PH_FILL;
        3, 4:    phase = PH_DRAIN;
        5, 6:    phase = PH_WALK;
        7, 8:    phase = PH_MIXED;
        default: phase = PH_NOISE;
      endcase
      len = $urandom_range(20, 90);
      // About one phase in four runs back to back with no idling on either side.
      if ($urandom_range(0, 3) == 0) begin
        tx_max_gap = 0;
        rx_max_gap = 0;
      end else begin
        tx_max_gap = 5;
        rx_max_gap = 5;
      end
      for (int n = 0; n < len; n++) begin
        req = pick_request(phase);
        send_request(req, pick_key(req == REQ_DELETE || req == REQ_FIND), 1'b0, '0);
        counted++;
      end
      if ($urandom_range(0, 7) == 0) wait_until_drained();
    end

    in_valid <= 1'b0;
    while (results_due.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
    if (failures == 0 && results_due.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #2000000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

// File: filelist.f
sv/sdlt_pkg.sv
sv/sdlt_cell.sv
sv/sorted_descending_list_table_core.sv
verif/tb_sorted_descending_list_table_core.sv
